>>> rtl/dbcr_pkg.sv
// dbcr_pkg: shared constants and types for the dark blob centroid block
// no dependencies
`timescale 1ns / 1ps
package dbcr_pkg;
   localparam int MaxWidth  = 2048;
   localparam int MaxHeight = 2048;
   localparam int PosW  = 11;
   localparam int CntW  = 23;
   localparam int SumW  = 34;
   localparam int OutW  = 15;
   localparam logic [22:0] AreaScale = 23'd5340354;

   localparam logic [2:0] REG_THRESHOLD = 3'd0;
   localparam logic [2:0] REG_COLOR     = 3'd1;
   localparam logic [2:0] REG_FRAME_W   = 3'd2;
   localparam logic [2:0] REG_FRAME_H   = 3'd3;
   localparam logic [2:0] REG_WIN_X     = 3'd4;
   localparam logic [2:0] REG_WIN_Y     = 3'd5;
   localparam logic [2:0] REG_WIN_W     = 3'd6;
   localparam logic [2:0] REG_WIN_H     = 3'd7;

   // totals of one finished frame, passed from front to back
   typedef struct packed {
      logic [CntW-1:0] count;
      logic [SumW-1:0] sum_x;
      logic [SumW-1:0] sum_y;
   } frame_sum_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCALE, ST_DIV_X, ST_DIV_Y, ST_ROOT, ST_DONE
   } back_state_type;
endpackage

>>> rtl/dark_blob_centroid_radius.sv
// dark_blob_centroid_radius: per-frame dark blob centroid and equal-area radius
// top level; depends on dbcr_pkg, dbcr_front, dbcr_queue, dbcr_back
//
// Usage: pixels enter in raster order on req_* (valid/stall), one per cycle.
// req_frame_start marks the first pixel of a frame and clears the sums.
// A frame also ends by itself after frame_width * frame_height pixels.
// On the last pixel the frame's count and moment sums go into a two-entry
// queue; the back end then divides both sums by the count (one quotient bit
// per cycle) and takes a bitwise square root, then registers rsp_valid and
// the result; it works on one frame at a time. Pixels stream at one per cycle;
// req_stall is high whenever the queue holds two unprocessed frames.
// The result register holds while rsp_stall is high; the back end then
// waits with its finished result and the queue fills behind it.
// Configuration is written through csr_* while no frame is in progress.
// Synchronous reset restores register defaults (threshold 65, 640x480 gray)
// and clears position, sums, queue and result valid.
`timescale 1ns / 1ps
module dark_blob_centroid_radius (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_blue_or_gray,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_red,
   input  logic        req_frame_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_detected,
   output logic [14:0] rsp_center_x_q4,
   output logic [14:0] rsp_center_y_q4,
   output logic [14:0] rsp_radius_q4,
   output logic [22:0] rsp_dark_area,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [11:0] csr_data
);
   import dbcr_pkg::*;

   logic [7:0]  thr_ff;
   logic        color_ff;
   logic [11:0] fw_ff, fh_ff, ww_ff, wh_ff;
   logic [10:0] wx_ff, wy_ff;
   frame_sum_type push_data, pop_data;
   logic push, full, not_empty, pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= 8'd65;
         color_ff <= 1'b0;
         fw_ff <= 12'd640;
         fh_ff <= 12'd480;
         wx_ff <= '0;
         wy_ff <= '0;
         ww_ff <= 12'd640;
         wh_ff <= 12'd480;
      end else if (csr_write) begin
         case (csr_index)
            REG_THRESHOLD: thr_ff <= csr_data[7:0];
            REG_COLOR:     color_ff <= csr_data[0];
            REG_FRAME_W:   fw_ff <= csr_data;
            REG_FRAME_H:   fh_ff <= csr_data;
            REG_WIN_X:     wx_ff <= csr_data[10:0];
            REG_WIN_Y:     wy_ff <= csr_data[10:0];
            REG_WIN_W:     ww_ff <= csr_data;
            REG_WIN_H:     wh_ff <= csr_data;
            default: ;
         endcase
      end
   end

   dbcr_front u_front (
      .clock(clock), .reset(reset),
      .pix_valid(req_valid), .pix_stall(req_stall),
      .blue_or_gray(req_blue_or_gray), .green(req_green), .red(req_red),
      .frame_start(req_frame_start),
      .dark_threshold(thr_ff), .color_input(color_ff),
      .frame_width(fw_ff), .frame_height(fh_ff),
      .window_x(wx_ff), .window_y(wy_ff),
      .window_width(ww_ff), .window_height(wh_ff),
      .sum_valid(push), .sum_full(full), .sum_data(push_data)
   );

   dbcr_queue u_queue (
      .clock(clock), .reset(reset),
      .push(push), .push_data(push_data), .full(full),
      .not_empty(not_empty), .pop(pop), .pop_data(pop_data)
   );

   dbcr_back u_back (
      .clock(clock), .reset(reset),
      .job_valid(not_empty), .job_data(pop_data), .job_pop(pop),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_detected(rsp_detected),
      .rsp_center_x_q4(rsp_center_x_q4), .rsp_center_y_q4(rsp_center_y_q4),
      .rsp_radius_q4(rsp_radius_q4), .rsp_dark_area(rsp_dark_area)
   );
endmodule

>>> rtl/dbcr_front.sv
// dbcr_front: luma conversion, window test and moment accumulation per pixel
// depends on dbcr_pkg
`timescale 1ns / 1ps
module dbcr_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          pix_valid,
   output logic                          pix_stall,
   input  logic [7:0]                    blue_or_gray,
   input  logic [7:0]                    green,
   input  logic [7:0]                    red,
   input  logic                          frame_start,
   input  logic [7:0]                    dark_threshold,
   input  logic                          color_input,
   input  logic [11:0]                   frame_width,
   input  logic [11:0]                   frame_height,
   input  logic [10:0]                   window_x,
   input  logic [10:0]                   window_y,
   input  logic [11:0]                   window_width,
   input  logic [11:0]                   window_height,
   output logic                          sum_valid,
   input  logic                          sum_full,
   output dbcr_pkg::frame_sum_type       sum_data
);
   import dbcr_pkg::*;

   logic [PosW-1:0] col_ff, col_in, line_ff, line_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [SumW-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic [PosW-1:0] col_eff, line_eff;
   logic [CntW-1:0] cnt_eff;
   logic [SumW-1:0] sx_eff, sy_eff;
   logic [12:0] fw, fh;
   logic [23:0] luma_sum;
   logic [7:0]  luma;
   logic [12:0] win_x_end, win_y_end;
   logic in_win, dark, last_col, last_line, take;

   always_comb begin
      if (frame_width == 12'd0) fw = 13'd1;
      else if ({1'b0, frame_width} > 13'(MaxWidth)) fw = 13'(MaxWidth);
      else fw = {1'b0, frame_width};
      if (frame_height == 12'd0) fh = 13'd1;
      else if ({1'b0, frame_height} > 13'(MaxHeight)) fh = 13'(MaxHeight);
      else fh = {1'b0, frame_height};
   end

   assign luma_sum = 24'd1868 * 24'(blue_or_gray) + 24'd9617 * 24'(green)
                   + 24'd4899 * 24'(red) + 24'd8192;
   assign luma = color_input ? luma_sum[21:14] : blue_or_gray;

   assign col_eff  = frame_start ? '0 : col_ff;
   assign line_eff = frame_start ? '0 : line_ff;
   assign cnt_eff  = frame_start ? '0 : cnt_ff;
   assign sx_eff   = frame_start ? '0 : sx_ff;
   assign sy_eff   = frame_start ? '0 : sy_ff;

   assign win_x_end = 13'(window_x) + 13'(window_width);
   assign win_y_end = 13'(window_y) + 13'(window_height);
   assign in_win = 13'(col_eff) < fw && 13'(line_eff) < fh
                && col_eff >= window_x && 13'(col_eff) < win_x_end
                && line_eff >= window_y && 13'(line_eff) < win_y_end;
   assign dark = in_win && (luma <= dark_threshold);
   assign last_col  = 13'(col_eff) + 13'd1 >= fw;
   assign last_line = 13'(line_eff) + 13'd1 >= fh;

   // stall while the queue holds two unprocessed frames
   assign pix_stall = sum_full;
   assign take = pix_valid && !pix_stall;

   always_comb begin
      cnt_in  = dark ? cnt_eff + 1'b1 : cnt_eff;
      sx_in   = dark ? sx_eff + SumW'(col_eff) : sx_eff;
      sy_in   = dark ? sy_eff + SumW'(line_eff) : sy_eff;
      col_in  = last_col ? '0 : col_eff + 1'b1;
      line_in = last_col ? (last_line ? '0 : line_eff + 1'b1) : line_eff;
      sum_valid = take && last_col && last_line;
      sum_data.count = cnt_in;
      sum_data.sum_x = sx_in;
      sum_data.sum_y = sy_in;
      if (sum_valid) begin
         cnt_in = '0;
         sx_in  = '0;
         sy_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         line_ff <= '0;
         cnt_ff  <= '0;
         sx_ff   <= '0;
         sy_ff   <= '0;
      end else if (take) begin
         col_ff  <= col_in;
         line_ff <= line_in;
         cnt_ff  <= cnt_in;
         sx_ff   <= sx_in;
         sy_ff   <= sy_in;
      end
   end
endmodule

>>> rtl/dbcr_queue.sv
// dbcr_queue: two-entry queue of frame totals between front and back
// depends on dbcr_pkg
`timescale 1ns / 1ps
module dbcr_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  dbcr_pkg::frame_sum_type push_data,
   output logic                    full,
   output logic                    not_empty,
   input  logic                    pop,
   output dbcr_pkg::frame_sum_type pop_data
);
   import dbcr_pkg::*;

   frame_sum_type mem_ff [2];
   logic wr_ff, rd_ff;
   logic [1:0] level_ff;

   assign full      = level_ff == 2'd2;
   assign not_empty = level_ff != 2'd0;
   assign pop_data  = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         level_ff <= '0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop) rd_ff <= !rd_ff;
         level_ff <= level_ff + 2'(push) - 2'(pop);
      end
   end
endmodule

>>> rtl/dbcr_back.sv
// dbcr_back: serial divider and square root producing one result per frame
// depends on dbcr_pkg
`timescale 1ns / 1ps
module dbcr_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    job_valid,
   input  dbcr_pkg::frame_sum_type job_data,
   output logic                    job_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_detected,
   output logic [14:0]             rsp_center_x_q4,
   output logic [14:0]             rsp_center_y_q4,
   output logic [14:0]             rsp_radius_q4,
   output logic [22:0]             rsp_dark_area
);
   import dbcr_pkg::*;

   localparam int NumW = SumW + 4;   // sum * 16
   localparam int ProdW = 46;
   localparam int RadW = 30;         // (count*k)>>16 fits in 30 bits

   back_state_type state_ff, state_in;
   logic [5:0]      step_ff, step_in;
   logic [CntW-1:0] cnt_ff;
   logic [SumW-1:0] sy_ff;
   logic [NumW-1:0] quo_ff, quo_in;
   logic [CntW:0]   rem_ff, rem_in;
   logic [RadW-1:0] rv_ff, rv_in;   // radicand remainder
   logic [RadW-1:0] root_ff, root_in;
   logic [RadW-1:0] rbit_ff, rbit_in;
   logic [ProdW-1:0] prod;
   logic [CntW:0]   trial;
   logic [RadW-1:0] rtrial;
   logic [14:0] cx_ff, cx_in, cy_ff, cy_in;
   logic load, out_load;
   logic [SumW-1:0] job_sx_hold;
   logic [SumW-1:0] sx_hold_ff;

   assign job_sx_hold = sx_hold_ff;
   assign prod = ProdW'(cnt_ff) * ProdW'(AreaScale);
   assign trial = {rem_ff[CntW-1:0], quo_ff[NumW-1]};
   assign rtrial = root_ff + rbit_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (job_valid) state_in = ST_SCALE;
         ST_SCALE: state_in = ST_DIV_X;
         ST_DIV_X: if (step_ff == 6'(NumW - 1)) state_in = ST_DIV_Y;
         ST_DIV_Y: if (step_ff == 6'(NumW - 1)) state_in = ST_ROOT;
         ST_ROOT:  if (rbit_ff[1:0] != 2'd0 || rbit_ff == '0) state_in = ST_DONE;
         ST_DONE:  if (!rsp_valid || !rsp_stall) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      load = state_ff == ST_IDLE && job_valid;
      job_pop = load;
      out_load = state_ff == ST_DONE && (!rsp_valid || !rsp_stall);
      step_in = step_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      rv_in = rv_ff;
      root_in = root_ff;
      rbit_in = rbit_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      case (state_ff)
         ST_SCALE: begin
            step_in = '0;
            rem_in = '0;
            quo_in = NumW'(job_sx_hold) << 4;
            rv_in = prod[RadW+15:16];
            root_in = '0;
            rbit_in = RadW'(1) << (RadW - 2);
         end
         ST_DIV_X, ST_DIV_Y: begin
            // restoring division, one quotient bit per cycle
            if (trial >= {1'b0, cnt_ff}) begin
               rem_in = trial - {1'b0, cnt_ff};
               quo_in = {quo_ff[NumW-2:0], 1'b1};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[NumW-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == 6'(NumW - 1)) begin
               step_in = '0;
               rem_in = '0;
               if (state_ff == ST_DIV_X) begin
                  cx_in = quo_in[14:0];
                  quo_in = NumW'(sy_ff) << 4;
               end else begin
                  cy_in = quo_in[14:0];
               end
            end
         end
         ST_ROOT: begin
            // bitwise square root, two radicand bits per cycle
            if (rv_ff >= rtrial) begin
               rv_in = rv_ff - rtrial;
               root_in = (root_ff >> 1) + rbit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            rbit_in = rbit_ff >> 2;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cnt_ff <= job_data.count;
         sx_hold_ff <= job_data.sum_x;
         sy_ff <= job_data.sum_y;
      end
      step_ff <= step_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      rv_ff <= rv_in;
      root_ff <= root_in;
      rbit_ff <= rbit_in;
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      if (out_load) begin
         rsp_detected <= cnt_ff != '0;
         rsp_center_x_q4 <= cnt_ff != '0 ? cx_ff : '0;
         rsp_center_y_q4 <= cnt_ff != '0 ? cy_ff : '0;
         rsp_radius_q4 <= root_ff[14:0];
         rsp_dark_area <= cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) rsp_valid <= 1'b1;
         else if (!rsp_stall) rsp_valid <= 1'b0;
      end
   end
endmodule

>>> tb/tb_dark_blob_centroid_radius.sv
// tb_dark_blob_centroid_radius: self-checking bench for the dark blob centroid block
// depends on dbcr_pkg and dark_blob_centroid_radius; frame model and scoreboard inline
`timescale 1ns / 1ps

class blob_scoreboard;
   logic [7:0]  thresh;
   logic        color;
   logic [11:0] fwidth, fheight, wwidth, wheight;
   logic [10:0] wx, wy;
   int unsigned col, line, total;
   longint unsigned sumc, suml;
   // detected, center x, center y, radius, area
   logic [68:0] expected_q[$];
   int errors;
   int frames;

   function void clear_frame();
      col = 0; line = 0; total = 0; sumc = 0; suml = 0;
   endfunction

   function void reset_regs();
      thresh = 65; color = 0; fwidth = 640; fheight = 480;
      wx = 0; wy = 0; wwidth = 640; wheight = 480;
      clear_frame();
      expected_q.delete();
   endfunction

   function void write_reg(logic [2:0] idx, logic [11:0] v);
      case (idx)
         dbcr_pkg::REG_THRESHOLD: thresh = v[7:0];
         dbcr_pkg::REG_COLOR:     color = v[0];
         dbcr_pkg::REG_FRAME_W:   fwidth = v;
         dbcr_pkg::REG_FRAME_H:   fheight = v;
         dbcr_pkg::REG_WIN_X:     wx = v[10:0];
         dbcr_pkg::REG_WIN_Y:     wy = v[10:0];
         dbcr_pkg::REG_WIN_W:     wwidth = v;
         dbcr_pkg::REG_WIN_H:     wheight = v;
         default: ;
      endcase
   endfunction

   static function longint unsigned isqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function void note_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic fs);
      int unsigned fw, fh, luma;
      bit in_win;
      longint unsigned n;
      logic [14:0] cx, cy, rad;
      fw = (fwidth == 0) ? 1 : (fwidth > 2048 ? 2048 : fwidth);
      fh = (fheight == 0) ? 1 : (fheight > 2048 ? 2048 : fheight);
      if (fs) clear_frame();
      if (color) luma = (1868 * b + 9617 * g + 4899 * r + 8192) >> 14;
      else luma = b;
      in_win = col < fw && line < fh && col >= wx && col < wx + wwidth &&
               line >= wy && line < wy + wheight;
      if (in_win && luma <= thresh) begin
         total++;
         sumc += col;
         suml += line;
      end
      if (col + 1 < fw) begin
         col++;
         return;
      end
      if (line + 1 < fh) begin
         col = 0;
         line++;
         return;
      end
      if (total == 0) begin
         expected_q.insert(expected_q.size(), '0);
      end else begin
         n = total;
         cx = 15'((sumc * 16) / n);
         cy = 15'((suml * 16) / n);
         rad = 15'(isqrt((n * 5340354) >> 16));
         expected_q.insert(expected_q.size(), {1'b1, cx, cy, rad, n[22:0]});
      end
      clear_frame();
   endfunction

   task report(string what, longint unsigned got, longint unsigned want);
      $display("mismatch in %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   task check_result(logic det, logic [14:0] cx, logic [14:0] cy, logic [14:0] rad,
                     logic [22:0] area);
      logic [68:0] e;
      frames++;
      if (expected_q.size() == 0) begin
         report("result with no frame pending", 1, 0);
         return;
      end
      e = expected_q[0];
      expected_q.delete(0);
      if (det !== e[68]) report("detected", det, e[68]);
      if (cx !== e[67:53]) report("center_x_q4", cx, e[67:53]);
      if (cy !== e[52:38]) report("center_y_q4", cy, e[52:38]);
      if (rad !== e[37:23]) report("radius_q4", rad, e[37:23]);
      if (area !== e[22:0]) report("dark_area", area, e[22:0]);
   endtask
endclass

module tb_dark_blob_centroid_radius;
   import dbcr_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [7:0]  req_blue_or_gray = 0, req_green = 0, req_red = 0;
   logic        req_frame_start = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic        rsp_detected;
   logic [14:0] rsp_center_x_q4, rsp_center_y_q4, rsp_radius_q4;
   logic [22:0] rsp_dark_area;
   logic        csr_write = 0;
   logic [2:0]  csr_index = 0;
   logic [11:0] csr_data = 0;

   blob_scoreboard frame_book;
   int  idle_cycles = 0;
   bit  long_hold;
   int  pixels_sent;

   dark_blob_centroid_radius uut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // valid stays high between back-to-back requests and drops only for a gap
   task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic fs,
                             bit allow_gap);
      int gap;
      gap = allow_gap ? int'($urandom_range(0, 14)) : 0;
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_blue_or_gray <= b; req_green <= g; req_red <= r; req_frame_start <= fs;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      frame_book.note_pixel(b, g, r, fs);
      pixels_sent++;
   endtask

   task automatic write_csr(logic [2:0] idx, logic [11:0] v);
      @(posedge clock);
      csr_write <= 1; csr_index <= idx; csr_data <= v;
      @(posedge clock);
      csr_write <= 0;
      frame_book.write_reg(idx, v);
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      while (frame_book.expected_q.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic set_frame(int fw, int fh, int x0, int y0, int ww, int wh, int th, int c);
      wait_drained();
      write_csr(REG_FRAME_W, 12'(fw));
      write_csr(REG_FRAME_H, 12'(fh));
      write_csr(REG_WIN_X, 12'(x0));
      write_csr(REG_WIN_Y, 12'(y0));
      write_csr(REG_WIN_W, 12'(ww));
      write_csr(REG_WIN_H, 12'(wh));
      write_csr(REG_THRESHOLD, 12'(th));
      write_csr(REG_COLOR, 12'(c));
   endtask

   // one frame; dark_bias steers how many pixels fall under the threshold
   task automatic send_frame(int npix, bit mark, bit allow_gap, int dark_bias);
      logic [7:0] b, g, r;
      for (int i = 0; i < npix; i++) begin
         b = 8'($urandom); g = 8'($urandom); r = 8'($urandom);
         if ($urandom_range(0, 99) < dark_bias) begin
            b = b >> 2; g = g >> 2; r = r >> 2;
         end
         send_pixel(b, g, r, mark && i == 0, allow_gap);
      end
   endtask

   // receiver: random stalls, one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else begin
         if (rsp_valid && !rsp_stall)
            frame_book.check_result(rsp_detected, rsp_center_x_q4, rsp_center_y_q4,
                                    rsp_radius_q4, rsp_dark_area);
         if (long_hold) rsp_stall <= 1;
         else if (idle_cycles > 0) idle_cycles <= idle_cycles - 1;
         else begin
            rsp_stall <= ($urandom_range(0, 2) == 0);
            idle_cycles <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
         end
      end
   end

   // watchdog: cycles with no accepted request, result or register write
   int quiet = 0;
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write)
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet > 200000) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      int fw, fh;
      frame_book = new();
      frame_book.reset_regs();
      long_hold = 0;
      pixels_sent = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: tiny frames, extremes of fields and window
      set_frame(2, 2, 0, 0, 2, 2, 255, 0);
      send_pixel(8'h00, 8'hff, 8'hff, 1'b1, 1'b0);
      send_pixel(8'hff, 8'h00, 8'h00, 1'b0, 1'b0);
      send_pixel(8'hff, 8'hff, 8'hff, 1'b0, 1'b0);
      send_pixel(8'h80, 8'h7f, 8'h01, 1'b0, 1'b0);
      set_frame(3, 1, 1, 0, 1, 4, 0, 1);
      send_pixel(8'h00, 8'h00, 8'h00, 1'b1, 1'b1);
      send_pixel(8'h00, 8'h00, 8'h00, 1'b0, 1'b1);
      send_pixel(8'h01, 8'h00, 8'h00, 1'b0, 1'b1);
      // empty window and window outside frame
      set_frame(2, 2, 2047, 2047, 0, 0, 255, 0);
      send_frame(4, 1'b1, 1'b0, 50);
      // sizes of zero act as one; frame_start in mid frame restarts
      set_frame(0, 0, 0, 0, 4095, 4095, 128, 0);
      send_frame(2, 1'b0, 1'b0, 50);
      set_frame(4, 3, 1, 1, 2, 1, 100, 1);
      send_frame(5, 1'b1, 1'b0, 50);
      send_frame(12, 1'b1, 1'b0, 50);

      // one long line frame, window running past the frame's right edge
      set_frame(600, 1, 300, 0, 2048, 1, 200, 0);
      send_frame(600, 1'b1, 1'b0, 70);

      // pressure: hold results while frames keep coming
      set_frame(3, 2, 0, 0, 3, 2, 128, 0);
      long_hold = 1;
      fork
         begin repeat (300) @(posedge clock); long_hold = 0; end
      join_none
      send_frame(60, 1'b1, 1'b0, 50);
      send_frame(30, 1'b0, 1'b1, 50);

      // random phases of small frames
      while (pixels_sent < 1900) begin
         fw = $urandom_range(1, 6);
         fh = $urandom_range(1, 5);
         set_frame(fw, fh, $urandom_range(0, 6), $urandom_range(0, 5),
                   $urandom_range(0, 7), $urandom_range(0, 6),
                   $urandom, $urandom_range(0, 1));
         repeat ($urandom_range(4, 12)) send_frame(fw * fh, 1'($urandom_range(0, 1)),
                                                    1'b1, $urandom_range(0, 100));
      end
      wait_drained();
      $display("covered %0d pixels and %0d frames, gray and color, clipped windows",
               pixels_sent, frame_book.frames);
      if (frame_book.errors == 0 && frame_book.expected_q.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule

>>> files.f
rtl/dbcr_pkg.sv
rtl/dbcr_front.sv
rtl/dbcr_queue.sv
rtl/dbcr_back.sv
rtl/dark_blob_centroid_radius.sv
tb/tb_dark_blob_centroid_radius.sv
